// ----- rtl/aging_drop_block_queue_assert.svh -----
// Assertion macros for the aging drop block queue.
`ifndef AGING_DROP_BLOCK_QUEUE_ASSERT_SVH
`define AGING_DROP_BLOCK_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define ADBQ_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adbq assertion failed");
`define ADBQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adbq assertion failed");
`else
`define ADBQ_ASSERT(lbl, clk, rst, ante, cons)
`define ADBQ_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/adbq_pkg.sv -----
// Shared types and codes of the aging drop block queue.
`default_nettype none
package adbq_pkg;
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_AGE  = 2'd2,
    OP_DROP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EVICTED = 2'd1,
    ST_REJECT  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  localparam logic [1:0] CFG_FORCE   = 2'd0;
  localparam logic [1:0] CFG_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_WARNING = 2'd2;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] size;
    logic [31:0] id;
    logic [31:0] lifetime;
  } entry_t;

  typedef struct packed {
    op_t         op;
    entry_t      blk;
    logic [31:0] now;
    logic [3:0]  start;
    logic [4:0]  stride;
    logic [4:0]  count;
  } req_t;
endpackage
`default_nettype wire

// ----- rtl/adbq_front.sv -----
// Front end: accepts and decodes requests into a two-entry queue.
`default_nettype none
module adbq_front import adbq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] block_tag,
  input  wire logic [31:0] block_size,
  input  wire logic [31:0] block_id,
  input  wire logic [31:0] block_lifetime,
  input  wire logic [31:0] block_time,
  input  wire logic [3:0]  drop_start,
  input  wire logic [4:0]  drop_stride,
  input  wire logic [4:0]  drop_count,
  output logic             req_valid,
  output req_t             req,
  input  wire logic        req_take
);
  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  req_t       incoming;

  assign busy      = (fill == 2'd2);
  assign req_valid = (fill != 2'd0);
  assign req       = slots[rd_ptr];
  assign push      = start && !busy;
  assign pop       = req_take && req_valid;

  always_comb begin
    incoming.op           = op_t'(cmd);
    incoming.blk.tag      = block_tag;
    incoming.blk.size     = block_size;
    incoming.blk.id       = block_id;
    incoming.blk.lifetime = block_lifetime;
    incoming.now          = block_time;
    incoming.start        = drop_start;
    incoming.stride       = drop_stride;
    incoming.count        = drop_count;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/adbq_back.sv -----
// Back end: ring store of descriptors and the command sequencer.
`default_nettype none
`include "aging_drop_block_queue_assert.svh"
module adbq_back import adbq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  req_t                  req,
  output logic                  req_take,
  input  wire logic             force_insert_new,
  input  wire logic [15:0]      check_period,
  input  wire logic [4:0]       warning_blocks,
  output logic                  done,
  output logic [1:0]            status,
  output logic [15:0]           out_tag,
  output logic [31:0]           out_size,
  output logic [31:0]           out_id,
  output logic [31:0]           out_lifetime,
  output logic [CNT_W-1:0]      removed_count,
  output logic [CNT_W-1:0]      occupancy,
  output logic [63:0]           total_bytes_taken,
  output logic [63:0]           total_bytes_lost
);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HIT_W = CNT_W + 5;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVICT = 6'b000010,
    S_POP   = 6'b000100,
    S_MOD   = 6'b001000,
    S_WRD   = 6'b010000,
    S_WWR   = 6'b100000
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [63:0]      taken;
  logic [63:0]      lost;
  req_t             cur;
  logic             is_age;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] wpos;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] removed;
  logic [HIT_W-1:0] hit_pos;
  logic [4:0]       hits_left;
  logic [15:0]      rem;
  logic [31:0]      dvd;
  logic [4:0]       step;
  logic [16:0]      trial;

  entry_t           mem [DEPTH];
  entry_t           rd_q;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;

  logic             expired;
  logic             age_drop;
  logic             idx_hit;
  logic             drop_it;
  logic [IDX_W-1:0] head_inc;
  logic [CNT_W-1:0] half1;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - IDX_W){1'b0}}, h} + {1'b0, pos};
    if (s >= (CNT_W + 1)'(DEPTH)) s = s - (CNT_W + 1)'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

  assign head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign half1    = (count >> 1) + CNT_W'(1);
  assign req_take = (state == S_IDLE) && req_valid;
  assign expired  = (rd_q.lifetime != 32'd0) &&
                    (({1'b0, rd_q.lifetime} + {1'b0, rd_q.id}) < {1'b0, cur.now});
  assign age_drop = expired && !(remain < warning_blocks);
  assign idx_hit  = ({{(HIT_W - CNT_W){1'b0}}, idx} == hit_pos) && (hits_left != 5'd0);
  assign drop_it  = is_age ? age_drop : idx_hit;
  assign trial    = {rem, dvd[31]};

  assign occupancy         = count;
  assign total_bytes_taken = taken;
  assign total_bytes_lost  = lost;

  // memory port controls
  always_comb begin
    we    = 1'b0;
    waddr = slot_of(head, count);
    wdata = req.blk;
    re    = 1'b0;
    raddr = head;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req.op == OP_PUSH) begin
          if (count < CNT_W'(DEPTH)) we = 1'b1;
          else re = force_insert_new;
        end else if (req_valid && req.op == OP_POP) begin
          re = 1'b1;
        end
      end
      S_EVICT: begin
        // new tail lands where the old head was
        we    = 1'b1;
        waddr = head;
        wdata = cur.blk;
      end
      S_WRD: begin
        re    = 1'b1;
        raddr = slot_of(head, idx);
      end
      S_WWR: begin
        we    = !drop_it;
        waddr = slot_of(head, wpos);
        wdata = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      taken   <= '0;
      lost    <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur           <= req;
            status        <= ST_DONE;
            out_tag       <= '0;
            out_size      <= '0;
            out_id        <= '0;
            out_lifetime  <= '0;
            removed_count <= '0;
            unique case (req.op)
              OP_PUSH: begin
                if (count < CNT_W'(DEPTH)) begin
                  count <= count + CNT_W'(1);
                  done  <= 1'b1;
                end else if (force_insert_new) begin
                  state <= S_EVICT;
                end else begin
                  lost   <= lost + {32'd0, req.blk.size};
                  status <= ST_REJECT;
                  done   <= 1'b1;
                end
              end
              OP_POP: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  done   <= 1'b1;
                end else begin
                  state <= S_POP;
                end
              end
              OP_AGE: begin
                if (check_period == 16'd0) begin
                  done <= 1'b1;
                end else begin
                  rem   <= '0;
                  dvd   <= req.now;
                  step  <= '0;
                  state <= S_MOD;
                end
              end
              OP_DROP: begin
                is_age    <= 1'b0;
                idx       <= '0;
                wpos      <= '0;
                removed   <= '0;
                remain    <= count;
                hit_pos   <= {{(HIT_W - 4){1'b0}}, req.start};
                hits_left <= req.count;
                state     <= S_WRD;
              end
              default: ;
            endcase
          end
        end
        S_EVICT: begin
          lost   <= lost + {32'd0, rd_q.size};
          head   <= head_inc;
          status <= ST_EVICTED;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_POP: begin
          out_tag      <= rd_q.tag;
          out_size     <= rd_q.size;
          out_id       <= rd_q.id;
          out_lifetime <= rd_q.lifetime;
          taken        <= taken + {32'd0, rd_q.size};
          head         <= head_inc;
          count        <= count - CNT_W'(1);
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        S_MOD: begin
          // one remainder bit per cycle
          if (trial >= {1'b0, check_period}) rem <= 16'(trial - {1'b0, check_period});
          else rem <= trial[15:0];
          dvd  <= {dvd[30:0], 1'b0};
          step <= step + 5'd1;
          if (step == 5'd31) begin
            if ((trial >= {1'b0, check_period} ? 17'(trial - {1'b0, check_period})
                 : trial) == 17'd0) begin
              is_age  <= 1'b1;
              idx     <= half1;
              wpos    <= half1;
              removed <= '0;
              remain  <= count;
              state   <= S_WRD;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_WRD: begin
          if (idx >= count) begin
            count         <= count - removed;
            removed_count <= removed;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_WWR;
          end
        end
        S_WWR: begin
          if (drop_it) begin
            lost    <= lost + {32'd0, rd_q.size};
            removed <= removed + CNT_W'(1);
            remain  <= remain - CNT_W'(1);
            if (!is_age) begin
              hit_pos   <= hit_pos + {{(HIT_W - 5){1'b0}}, cur.stride};
              hits_left <= (cur.stride == 5'd0) ? 5'd0 : hits_left - 5'd1;
            end
          end else begin
            wpos <= wpos + CNT_W'(1);
          end
          idx   <= idx + CNT_W'(1);
          state <= S_WRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ADBQ_ASSERT(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ADBQ_ASSERT(a_empty_pop, clk, rst, done && status == ST_EMPTY, occupancy == '0)
  `ADBQ_ASSERT_NXT(a_walk_write, clk, rst, state == S_WWR, wpos <= idx)
endmodule
`default_nettype wire

// ----- rtl/aging_drop_block_queue.sv -----
// Top level of the aging drop block queue.
// Usage: pulse start with cmd and its fields while busy is low; the request
// is taken at that edge. Each request gives one result: done is high for
// one cycle with status, popped descriptor, removed_count, occupancy and
// the running byte totals. The receiver cannot stall; results are never
// held back.
// A two-entry request queue sits in front of the sequencer, so busy rises
// only when both entries wait. Age runs a bit-serial remainder and then
// walks the back half of the queue, reading and then writing each entry
// through the single-port descriptor store; drop by index walks all entries
// the same way. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle, as the block does not enforce it.
// Reset clears the queue, the byte totals and the registers; no clearing
// pass runs on the descriptor store.
`default_nettype none
module aging_drop_block_queue import adbq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       cmd,
  input  wire logic [15:0]      block_tag,
  input  wire logic [31:0]      block_size,
  input  wire logic [31:0]      block_id,
  input  wire logic [31:0]      block_lifetime,
  input  wire logic [31:0]      block_time,
  input  wire logic [3:0]       drop_start,
  input  wire logic [4:0]       drop_stride,
  input  wire logic [4:0]       drop_count,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  output logic                  done,
  output logic [1:0]            status,
  output logic [15:0]           out_tag,
  output logic [31:0]           out_size,
  output logic [31:0]           out_id,
  output logic [31:0]           out_lifetime,
  output logic [CNT_W-1:0]      removed_count,
  output logic [CNT_W-1:0]      occupancy,
  output logic [63:0]           total_bytes_taken,
  output logic [63:0]           total_bytes_lost
);
  logic        force_insert_new;
  logic [15:0] check_period;
  logic [4:0]  warning_blocks;
  logic        req_valid;
  req_t        req;
  logic        req_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_insert_new <= 1'b0;
      check_period     <= '0;
      warning_blocks   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORCE:   force_insert_new <= cfg_data[0];
        CFG_PERIOD:  check_period     <= cfg_data;
        CFG_WARNING: warning_blocks   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  adbq_front u_front (
    .clk, .rst, .start, .busy, .cmd, .block_tag, .block_size, .block_id,
    .block_lifetime, .block_time, .drop_start, .drop_stride, .drop_count,
    .req_valid, .req, .req_take
  );

  adbq_back #(.DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W)) u_back (
    .clk, .rst, .req_valid, .req, .req_take,
    .force_insert_new, .check_period, .warning_blocks,
    .done, .status, .out_tag, .out_size, .out_id, .out_lifetime,
    .removed_count, .occupancy, .total_bytes_taken, .total_bytes_lost
  );
endmodule
`default_nettype wire
